FILE: hdl/readout_channel_pad_mapper_unit_macros.svh
// assertion macros shared by the pad mapper rtl
`ifndef READOUT_CHANNEL_PAD_MAPPER_UNIT_MACROS_SVH
`define READOUT_CHANNEL_PAD_MAPPER_UNIT_MACROS_SVH

// same-cycle implication
`define RCPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rcpm_pkg.sv
`timescale 1ns / 1ps
// shared constants, codes and types of the pad mapper
package rcpm_pkg;

    localparam int NUM_BOARDS      = 12;
    localparam int SLOTS_PER_BOARD = 4;
    localparam int NUM_CHANNELS    = 68;

    localparam int NUM_UNITS = NUM_BOARDS * SLOTS_PER_BOARD;
    localparam int UNIT_AW   = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int CHAN_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SCAN_LEN  = (NUM_UNITS > NUM_CHANNELS) ? NUM_UNITS : NUM_CHANNELS;
    localparam int SCAN_W    = $clog2(SCAN_LEN + 1);

    localparam int ROWS_PER_SECTION   = 9;
    localparam int LAYERS_PER_QUARTER = 28;
    localparam int LAYERS_PER_CHIP    = 7;
    localparam int MIRROR_SECTION     = 6;
    localparam int PAD_ROWS           = 108;
    localparam int PAD_LAYERS         = 112;
    localparam int TOP_CHIP           = 3;
    localparam int TOP_LOCAL_ROW      = 8;
    localparam int TOP_LOCAL_LAYER    = 6;

    // shared multiply-add unit widths
    localparam int ALU_W  = 10;
    localparam int ALU_KW = 6;
    localparam int ALU_YW = 16;

    localparam int IN_W   = 48;
    localparam int OUT_W  = 48;
    localparam int USER_W = 3;

    typedef enum logic [2:0] {
        CMD_WR_UNIT = 3'd0,
        CMD_WR_CHAN = 3'd1,
        CMD_FWD     = 3'd2,
        CMD_REV     = 3'd3,
        CMD_READ    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_CHAN_UNMAPPED = 3'd1,
        ST_UNIT_UNMAPPED = 3'd2,
        ST_PAD_RANGE     = 3'd3,
        ST_UNIT_MISSING  = 3'd4,
        ST_CHAN_MISSING  = 3'd5
    } t_status;

    // command payload, last member in the lowest bits
    typedef struct packed {
        logic [4:0] pad;
        logic       entry_valid;
        logic [2:0] local_layer;
        logic [3:0] local_row;
        logic [3:0] section;
        logic [1:0] quarter;
        logic [6:0] pad_layer;
        logic [6:0] pad_row;
        logic [6:0] channel;
        logic [1:0] chip;
        logic [1:0] slot;
        logic [3:0] board;
    } t_in_data;

    typedef struct packed {
        logic [5:0] pad;
        logic [2:0] read_layer;
        logic [3:0] read_row;
        logic [6:0] out_channel;
        logic [1:0] out_chip;
        logic [1:0] out_slot;
        logic [3:0] out_board;
        logic [3:0] out_section;
        logic [1:0] out_quarter;
        logic [6:0] out_layer;
        logic [6:0] out_row;
    } t_out_data;

    typedef struct packed {
        logic       valid;
        logic [1:0] quarter;
        logic [3:0] section;
    } t_unit_rd;

    typedef struct packed {
        logic       valid;
        logic [3:0] row;
        logic [2:0] layer;
    } t_chan_rd;

    typedef struct packed {
        logic               unit_we;
        logic [UNIT_AW-1:0] unit_addr;
        t_unit_rd           unit_wr;
        logic               chan_we;
        logic [CHAN_AW-1:0] chan_addr;
        t_chan_rd           chan_wr;
    } t_tbl_req;

endpackage

FILE: hdl/rcpm_alu.sv
`timescale 1ns / 1ps
// shared signed multiply-add unit, y = a * k + b
module rcpm_alu (
    input  logic signed [rcpm_pkg::ALU_W-1:0]  i_a,
    input  logic signed [rcpm_pkg::ALU_KW-1:0] i_k,
    input  logic signed [rcpm_pkg::ALU_W-1:0]  i_b,
    output logic signed [rcpm_pkg::ALU_YW-1:0] o_y
);

    logic signed [rcpm_pkg::ALU_YW-1:0] w_a;
    logic signed [rcpm_pkg::ALU_YW-1:0] w_k;
    logic signed [rcpm_pkg::ALU_YW-1:0] w_b;

    assign w_a = rcpm_pkg::ALU_YW'(i_a);
    assign w_k = rcpm_pkg::ALU_YW'(i_k);
    assign w_b = rcpm_pkg::ALU_YW'(i_b);
    assign o_y = w_a * w_k + w_b;

endmodule

FILE: hdl/rcpm_tables.sv
`timescale 1ns / 1ps
// unit and channel lookup memories with valid bits and registered reads
`include "readout_channel_pad_mapper_unit_macros.svh"
module rcpm_tables (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcpm_pkg::t_tbl_req  i_req,
    output rcpm_pkg::t_unit_rd  o_unit_rd,
    output rcpm_pkg::t_chan_rd  o_chan_rd
);

    logic [5:0] r_unit_mem [rcpm_pkg::NUM_UNITS];
    logic [6:0] r_chan_mem [rcpm_pkg::NUM_CHANNELS];
    logic       r_unit_vld [rcpm_pkg::NUM_UNITS];
    logic       r_chan_vld [rcpm_pkg::NUM_CHANNELS];

    rcpm_pkg::t_unit_rd r_unit_rd;
    rcpm_pkg::t_chan_rd r_chan_rd;

    // valid bits, cleared at reset so every entry reads unmapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rcpm_pkg::NUM_UNITS; i++) begin
                r_unit_vld[i] <= 1'b0;
            end
            for (int i = 0; i < rcpm_pkg::NUM_CHANNELS; i++) begin
                r_chan_vld[i] <= 1'b0;
            end
        end else begin
            if (i_req.unit_we) begin
                r_unit_vld[i_req.unit_addr] <= i_req.unit_wr.valid;
            end
            if (i_req.chan_we) begin
                r_chan_vld[i_req.chan_addr] <= i_req.chan_wr.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.unit_we) begin
            r_unit_mem[i_req.unit_addr] <= {i_req.unit_wr.quarter, i_req.unit_wr.section};
        end
        r_unit_rd.valid                        <= r_unit_vld[i_req.unit_addr];
        {r_unit_rd.quarter, r_unit_rd.section} <= r_unit_mem[i_req.unit_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.chan_we) begin
            r_chan_mem[i_req.chan_addr] <= {i_req.chan_wr.row, i_req.chan_wr.layer};
        end
        r_chan_rd.valid                    <= r_chan_vld[i_req.chan_addr];
        {r_chan_rd.row, r_chan_rd.layer}   <= r_chan_mem[i_req.chan_addr];
    end

    assign o_unit_rd = r_unit_rd;
    assign o_chan_rd = r_chan_rd;

    `RCPM_ASSERT_IMP(a_unit_wr_in_range, i_clk, i_rst_n, i_req.unit_we, ({1'b0, i_req.unit_addr} < (rcpm_pkg::UNIT_AW + 1)'(rcpm_pkg::NUM_UNITS)), "unit table write beyond its depth")
    `RCPM_ASSERT_IMP(a_chan_wr_in_range, i_clk, i_rst_n, i_req.chan_we, ({1'b0, i_req.chan_addr} < (rcpm_pkg::CHAN_AW + 1)'(rcpm_pkg::NUM_CHANNELS)), "channel table write beyond its depth")

endmodule

FILE: hdl/readout_channel_pad_mapper_unit.sv
`timescale 1ns / 1ps
// top level of the readout channel to pad mapper: sequencer, output register
//
//  port group | dir | tdata (from bit 0 up)                    | tuser
//  -----------+-----+------------------------------------------+--------
//  s_axis     | in  | board slot chip channel pad_row          | cmd
//             |     | pad_layer quarter section local_row      |
//             |     | local_layer entry_valid, zero fill       |
//  m_axis     | out | out_row out_layer out_quarter out_section | status
//             |     | out_board out_slot out_chip out_channel  |
//             |     | read_row read_layer, zero fill           |
//
// a forward map ends early when an entry is unmapped and a reverse map when the pad
// is off the plane; otherwise the reverse map does one subtract a cycle in the shared
// multiply-add unit for the section, quarter and chip divisions, then reads one entry
// of the larger table a cycle over the memory read ports
// reset is synchronous, active low; both tables read as unmapped right after it
// s_axis_tready is high only while the sequencer is idle; a result waiting on
// m_axis does not stop the next transaction from being accepted
`include "readout_channel_pad_mapper_unit_macros.svh"
module readout_channel_pad_mapper_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // board, slot, chip, channel, pad_row, pad_layer, quarter, section,
    // local_row, local_layer, entry_valid, zero fill
    input  logic [rcpm_pkg::IN_W-1:0]     s_axis_tdata,
    // cmd
    input  logic [rcpm_pkg::USER_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_row, out_layer, out_quarter, out_section, out_board, out_slot,
    // out_chip, out_channel, read_row, read_layer, zero fill
    output logic [rcpm_pkg::OUT_W-1:0]    m_axis_tdata,
    // status
    output logic [rcpm_pkg::USER_W-1:0]   m_axis_tuser
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_READ_DONE,
        S_FWD_READ,
        S_FWD_CHECK,
        S_FWD_ROW,
        S_FWD_CHIP,
        S_FWD_LAYER,
        S_FWD_RANGE,
        S_REV_CHECK,
        S_REV_SEC,
        S_REV_QTR,
        S_REV_CHIP,
        S_REV_SCAN,
        S_REV_DRAIN,
        S_REV_DONE,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic [2:0]                       r_cmd;
    rcpm_pkg::t_in_data               r_in;
    rcpm_pkg::t_out_data              r_res;
    rcpm_pkg::t_status                r_status;
    logic                             r_m_valid;
    logic [rcpm_pkg::OUT_W-1:0]       r_m_data;
    logic [rcpm_pkg::USER_W-1:0]      r_m_user;

    // forward map partial results
    logic signed [rcpm_pkg::ALU_W-1:0] r_row;
    logic signed [rcpm_pkg::ALU_W-1:0] r_acc;
    logic signed [rcpm_pkg::ALU_W-1:0] r_lay;

    // reverse map divider and scan state
    logic signed [rcpm_pkg::ALU_W-1:0] r_rem;
    logic [3:0]                        r_q_sec;
    logic [1:0]                        r_q_qtr;
    logic [1:0]                        r_q_cg;
    logic [3:0]                        r_inrow;
    logic [rcpm_pkg::SCAN_W-1:0]       r_idx;
    logic [3:0]                        r_scan_board;
    logic [1:0]                        r_scan_slot;
    logic                              r_p_u;
    logic                              r_p_c;
    logic [rcpm_pkg::CHAN_AW-1:0]      r_p_idx;
    logic [3:0]                        r_p_board;
    logic [1:0]                        r_p_slot;
    logic                              r_ufound;
    logic                              r_cfound;

    rcpm_pkg::t_tbl_req                w_req;
    rcpm_pkg::t_unit_rd                w_unit_rd;
    rcpm_pkg::t_chan_rd                w_chan_rd;

    logic signed [rcpm_pkg::ALU_W-1:0]  w_alu_a;
    logic signed [rcpm_pkg::ALU_KW-1:0] w_alu_k;
    logic signed [rcpm_pkg::ALU_W-1:0]  w_alu_b;
    logic signed [rcpm_pkg::ALU_YW-1:0] w_y;

    logic [5:0]        w_uidx;
    logic              w_unit_ok;
    logic              w_chan_ok;
    logic              w_fmir;
    logic signed [4:0] w_fr_local;
    logic signed [3:0] w_fl_local;
    logic [1:0]        w_fchip;
    logic              w_rmir;

    // index checks on the registered command
    assign w_uidx    = 6'(32'(r_in.board) * rcpm_pkg::SLOTS_PER_BOARD + 32'(r_in.slot));
    assign w_unit_ok = ({1'b0, r_in.board} < 5'(rcpm_pkg::NUM_BOARDS))
                    && ({1'b0, r_in.slot} < 3'(rcpm_pkg::SLOTS_PER_BOARD));
    assign w_chan_ok = ({1'b0, r_in.channel} < 8'(rcpm_pkg::NUM_CHANNELS));

    // forward map terms: row and layer flipped in mirrored sections, chip in others
    assign w_fmir     = (w_unit_rd.section >= 4'(rcpm_pkg::MIRROR_SECTION));
    assign w_fr_local = w_fmir ? (5'(rcpm_pkg::TOP_LOCAL_ROW) - {1'b0, w_chan_rd.row})
                               : {1'b0, w_chan_rd.row};
    assign w_fl_local = w_fmir ? (4'(rcpm_pkg::TOP_LOCAL_LAYER) - {1'b0, w_chan_rd.layer})
                               : {1'b0, w_chan_rd.layer};
    assign w_fchip    = w_fmir ? r_in.chip : (2'(rcpm_pkg::TOP_CHIP) - r_in.chip);

    assign w_rmir = (r_q_sec >= 4'(rcpm_pkg::MIRROR_SECTION));

    // table port: scan addresses during the reverse search, else the command's
    always_comb begin
        w_req.unit_we         = (r_state == S_WRITE) && (r_cmd == rcpm_pkg::CMD_WR_UNIT)
                             && w_unit_ok;
        w_req.unit_wr.valid   = r_in.entry_valid;
        w_req.unit_wr.quarter = r_in.quarter;
        w_req.unit_wr.section = r_in.section;
        w_req.chan_we         = (r_state == S_WRITE) && (r_cmd == rcpm_pkg::CMD_WR_CHAN)
                             && w_chan_ok;
        w_req.chan_wr.valid   = r_in.entry_valid;
        w_req.chan_wr.row     = r_in.local_row;
        w_req.chan_wr.layer   = r_in.local_layer;
        if (r_state == S_REV_SCAN) begin
            w_req.unit_addr = r_idx[rcpm_pkg::UNIT_AW-1:0];
            w_req.chan_addr = r_idx[rcpm_pkg::CHAN_AW-1:0];
        end else begin
            w_req.unit_addr = w_uidx[rcpm_pkg::UNIT_AW-1:0];
            w_req.chan_addr = r_in.channel[rcpm_pkg::CHAN_AW-1:0];
        end
    end

    rcpm_tables u_tables (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_unit_rd (w_unit_rd),
        .o_chan_rd (w_chan_rd)
    );

    // operand select for the shared multiply-add unit
    always_comb begin
        w_alu_a = '0;
        w_alu_k = '0;
        w_alu_b = '0;
        unique case (r_state)
            S_FWD_ROW: begin
                w_alu_a = rcpm_pkg::ALU_W'(w_unit_rd.section);
                w_alu_k = rcpm_pkg::ALU_KW'(rcpm_pkg::ROWS_PER_SECTION);
                w_alu_b = rcpm_pkg::ALU_W'(w_fr_local);
            end
            S_FWD_CHIP: begin
                w_alu_a = rcpm_pkg::ALU_W'(w_fchip);
                w_alu_k = rcpm_pkg::ALU_KW'(rcpm_pkg::LAYERS_PER_CHIP);
                w_alu_b = rcpm_pkg::ALU_W'(w_fl_local);
            end
            S_FWD_LAYER: begin
                w_alu_a = rcpm_pkg::ALU_W'(w_unit_rd.quarter);
                w_alu_k = rcpm_pkg::ALU_KW'(rcpm_pkg::LAYERS_PER_QUARTER);
                w_alu_b = r_acc;
            end
            S_REV_SEC: begin
                w_alu_a = r_rem;
                w_alu_k = rcpm_pkg::ALU_KW'(1);
                w_alu_b = rcpm_pkg::ALU_W'(-rcpm_pkg::ROWS_PER_SECTION);
            end
            S_REV_QTR: begin
                w_alu_a = r_rem;
                w_alu_k = rcpm_pkg::ALU_KW'(1);
                w_alu_b = rcpm_pkg::ALU_W'(-rcpm_pkg::LAYERS_PER_QUARTER);
            end
            S_REV_CHIP: begin
                w_alu_a = r_rem;
                w_alu_k = rcpm_pkg::ALU_KW'(1);
                w_alu_b = rcpm_pkg::ALU_W'(-rcpm_pkg::LAYERS_PER_CHIP);
            end
            default: begin
                w_alu_a = '0;
            end
        endcase
    end

    rcpm_alu u_alu (
        .i_a (w_alu_a),
        .i_k (w_alu_k),
        .i_b (w_alu_b),
        .o_y (w_y)
    );

    // sequencer, result and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_p_u     <= 1'b0;
            r_p_c     <= 1'b0;
            r_ufound  <= 1'b0;
            r_cfound  <= 1'b0;
        end else begin
            // a new result in the emit state takes over the slot itself
            if (r_m_valid && m_axis_tready && (r_state != S_EMIT)) begin
                r_m_valid <= 1'b0;
            end

            // scan pipeline: table data arrives in the cycle after its address
            r_p_u     <= (r_state == S_REV_SCAN)
                      && (r_idx < rcpm_pkg::SCAN_W'(rcpm_pkg::NUM_UNITS));
            r_p_c     <= (r_state == S_REV_SCAN)
                      && (r_idx < rcpm_pkg::SCAN_W'(rcpm_pkg::NUM_CHANNELS));
            r_p_idx   <= r_idx[rcpm_pkg::CHAN_AW-1:0];
            r_p_board <= r_scan_board;
            r_p_slot  <= r_scan_slot;

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd    <= s_axis_tuser;
                        r_in     <= rcpm_pkg::t_in_data'(s_axis_tdata);
                        r_res    <= '0;
                        r_status <= rcpm_pkg::ST_OK;
                        unique case (s_axis_tuser)
                            rcpm_pkg::CMD_WR_UNIT,
                            rcpm_pkg::CMD_WR_CHAN: r_state <= S_WRITE;
                            rcpm_pkg::CMD_FWD:     r_state <= S_FWD_READ;
                            rcpm_pkg::CMD_REV:     r_state <= S_REV_CHECK;
                            rcpm_pkg::CMD_READ:    r_state <= S_READ;
                            default:               r_state <= S_EMIT;
                        endcase
                    end
                end
                S_WRITE: begin
                    r_state <= S_EMIT;
                end
                S_READ: begin
                    r_state <= S_READ_DONE;
                end
                S_READ_DONE: begin
                    if (w_chan_ok && w_chan_rd.valid) begin
                        r_res.read_row   <= w_chan_rd.row;
                        r_res.read_layer <= w_chan_rd.layer;
                    end else begin
                        r_status <= rcpm_pkg::ST_CHAN_UNMAPPED;
                    end
                    r_state <= S_EMIT;
                end
                S_FWD_READ: begin
                    r_state <= S_FWD_CHECK;
                end
                S_FWD_CHECK: begin
                    // channel is checked before unit
                    if (!(w_chan_ok && w_chan_rd.valid)) begin
                        r_status <= rcpm_pkg::ST_CHAN_UNMAPPED;
                        r_state  <= S_EMIT;
                    end else if (!(w_unit_ok && w_unit_rd.valid)) begin
                        r_status <= rcpm_pkg::ST_UNIT_UNMAPPED;
                        r_state  <= S_EMIT;
                    end else begin
                        r_state <= S_FWD_ROW;
                    end
                end
                S_FWD_ROW: begin
                    r_row   <= w_y[rcpm_pkg::ALU_W-1:0];
                    r_state <= S_FWD_CHIP;
                end
                S_FWD_CHIP: begin
                    r_acc   <= w_y[rcpm_pkg::ALU_W-1:0];
                    r_state <= S_FWD_LAYER;
                end
                S_FWD_LAYER: begin
                    r_lay   <= w_y[rcpm_pkg::ALU_W-1:0];
                    r_state <= S_FWD_RANGE;
                end
                S_FWD_RANGE: begin
                    // off the pad plane when a stored value lies beyond its range
                    if (r_row[rcpm_pkg::ALU_W-1] || r_lay[rcpm_pkg::ALU_W-1]
                        || (r_row >= rcpm_pkg::ALU_W'(rcpm_pkg::PAD_ROWS))
                        || (r_lay >= rcpm_pkg::ALU_W'(rcpm_pkg::PAD_LAYERS))) begin
                        r_status <= rcpm_pkg::ST_PAD_RANGE;
                    end else begin
                        r_res.out_row   <= r_row[6:0];
                        r_res.out_layer <= r_lay[6:0];
                    end
                    r_state <= S_EMIT;
                end
                S_REV_CHECK: begin
                    if ((r_in.pad_row >= 7'(rcpm_pkg::PAD_ROWS))
                        || (r_in.pad_layer >= 7'(rcpm_pkg::PAD_LAYERS))) begin
                        r_status <= rcpm_pkg::ST_PAD_RANGE;
                        r_state  <= S_EMIT;
                    end else begin
                        r_rem   <= rcpm_pkg::ALU_W'(r_in.pad_row);
                        r_q_sec <= '0;
                        r_q_qtr <= '0;
                        r_q_cg  <= '0;
                        r_state <= S_REV_SEC;
                    end
                end
                S_REV_SEC: begin
                    if (!w_y[rcpm_pkg::ALU_YW-1]) begin
                        r_rem   <= w_y[rcpm_pkg::ALU_W-1:0];
                        r_q_sec <= r_q_sec + 4'd1;
                    end else begin
                        r_inrow <= r_rem[3:0];
                        r_rem   <= rcpm_pkg::ALU_W'(r_in.pad_layer);
                        r_state <= S_REV_QTR;
                    end
                end
                S_REV_QTR: begin
                    if (!w_y[rcpm_pkg::ALU_YW-1]) begin
                        r_rem   <= w_y[rcpm_pkg::ALU_W-1:0];
                        r_q_qtr <= r_q_qtr + 2'd1;
                    end else begin
                        r_state <= S_REV_CHIP;
                    end
                end
                S_REV_CHIP: begin
                    if (!w_y[rcpm_pkg::ALU_YW-1]) begin
                        r_rem  <= w_y[rcpm_pkg::ALU_W-1:0];
                        r_q_cg <= r_q_cg + 2'd1;
                    end else begin
                        r_res.out_quarter <= r_q_qtr;
                        r_res.out_section <= r_q_sec;
                        if (w_rmir) begin
                            r_res.out_chip   <= r_q_cg;
                            r_res.read_row   <= 4'(rcpm_pkg::TOP_LOCAL_ROW) - r_inrow;
                            r_res.read_layer <= 3'(rcpm_pkg::TOP_LOCAL_LAYER) - r_rem[2:0];
                        end else begin
                            r_res.out_chip   <= 2'(rcpm_pkg::TOP_CHIP) - r_q_cg;
                            r_res.read_row   <= r_inrow;
                            r_res.read_layer <= r_rem[2:0];
                        end
                        r_idx        <= '0;
                        r_scan_board <= '0;
                        r_scan_slot  <= '0;
                        r_ufound     <= 1'b0;
                        r_cfound     <= 1'b0;
                        r_state      <= S_REV_SCAN;
                    end
                end
                S_REV_SCAN: begin
                    r_idx <= r_idx + rcpm_pkg::SCAN_W'(1);
                    if (r_scan_slot == 2'(rcpm_pkg::SLOTS_PER_BOARD - 1)) begin
                        r_scan_slot  <= '0;
                        r_scan_board <= r_scan_board + 4'd1;
                    end else begin
                        r_scan_slot <= r_scan_slot + 2'd1;
                    end
                    if (r_idx == rcpm_pkg::SCAN_W'(rcpm_pkg::SCAN_LEN - 1)) begin
                        r_state <= S_REV_DRAIN;
                    end
                end
                S_REV_DRAIN: begin
                    r_state <= S_REV_DONE;
                end
                S_REV_DONE: begin
                    if (!r_ufound) begin
                        r_status <= rcpm_pkg::ST_UNIT_MISSING;
                    end else if (!r_cfound) begin
                        r_status <= rcpm_pkg::ST_CHAN_MISSING;
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res;
                        r_m_user  <= r_status;
                        r_state   <= S_IDLE;
                    end else if (r_m_valid && m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // first matching unit entry, board-major
            if (r_p_u && !r_ufound && w_unit_rd.valid
                && (w_unit_rd.quarter == r_res.out_quarter)
                && (w_unit_rd.section == r_res.out_section)) begin
                r_ufound        <= 1'b1;
                r_res.out_board <= r_p_board;
                r_res.out_slot  <= r_p_slot;
            end
            // lowest matching channel
            if (r_p_c && !r_cfound && w_chan_rd.valid
                && (w_chan_rd.row == r_res.read_row)
                && (w_chan_rd.layer == r_res.read_layer)) begin
                r_cfound          <= 1'b1;
                r_res.out_channel <= 7'(r_p_idx);
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    `RCPM_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state != S_IDLE, "accepted transaction did not start the sequencer")
    `RCPM_ASSERT_IMP(a_write_result_zero, i_clk, i_rst_n, (r_state == S_EMIT) && (r_cmd == rcpm_pkg::CMD_WR_UNIT || r_cmd == rcpm_pkg::CMD_WR_CHAN), (r_res == '0) && (r_status == rcpm_pkg::ST_OK), "table write result carries data")
    `RCPM_ASSERT_IMP(a_rev_ok_found, i_clk, i_rst_n, (r_state == S_EMIT) && (r_cmd == rcpm_pkg::CMD_REV) && (r_status == rcpm_pkg::ST_OK), r_ufound && r_cfound, "reverse map ok without both matches")
    `RCPM_ASSERT_IMP(a_fwd_on_plane, i_clk, i_rst_n, (r_state == S_EMIT) && (r_cmd == rcpm_pkg::CMD_FWD) && (r_status == rcpm_pkg::ST_OK), (r_res.out_row < 7'(rcpm_pkg::PAD_ROWS)) && (r_res.out_layer < 7'(rcpm_pkg::PAD_LAYERS)), "forward map ok with pad off the plane")

endmodule

FILE: sim/tb_readout_channel_pad_mapper_unit.sv
`timescale 1ns / 1ps
// self-checking testbench for the readout channel to pad mapper
module tb_readout_channel_pad_mapper_unit;
    import rcpm_pkg::*;

    // command codes the block leaves without effect
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 1250;
    localparam int FILL_ITEMS   = 60;    // leading table writes so lookups mostly hit
    localparam int DRAIN_CYCLES = 120;   // longer than the slowest reverse map
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic [2:0] op;
        t_in_data   d;
    } mapper_req_t;

    typedef struct packed {
        logic [2:0] st;
        t_out_data  o;
    } pad_result_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic [USER_W-1:0] s_axis_tuser  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;

    readout_channel_pad_mapper_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow copies of the two tables
    logic       unit_mapped  [NUM_UNITS];
    logic [1:0] unit_quarter [NUM_UNITS];
    logic [3:0] unit_section [NUM_UNITS];
    logic       chan_mapped  [NUM_CHANNELS];
    logic [3:0] chan_row     [NUM_CHANNELS];
    logic [2:0] chan_layer   [NUM_CHANNELS];

    mapper_req_t pending_reqs[$];
    pad_result_t pad_results_due[$];
    mapper_req_t cur_req;

    int n_requests_total    = 0;
    int n_requests_accepted = 0;
    int n_results_seen      = 0;
    int n_mismatches        = 0;
    int send_gap            = 0;
    int stall_left          = 0;
    int hold_left           = 0;
    logic calm;

    // every fourth window of 64 transactions runs with no idling on either side
    assign calm = ((n_requests_accepted / 64) % 4) == 1;

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    // value in the legal range, one in ten above it up to the field's top
    function automatic logic [6:0] pick_field(int legal_max, int field_max);
        if (legal_max >= field_max || $urandom_range(0, 9) != 0)
            return 7'($urandom_range(0, legal_max));
        return 7'($urandom_range(legal_max + 1, field_max));
    endfunction

    // table updates and expected result for one accepted transaction
    task automatic predict_pad_result(input mapper_req_t req, output pad_result_t res);
        int  ui, i, sec, qtr, lr, ll, chip, row, lay, prow, play, inrow, inlay;
        logic unit_hit, chan_hit;
        res    = '0;
        res.st = ST_OK;
        ui     = int'(req.d.board) * SLOTS_PER_BOARD + int'(req.d.slot);
        case (req.op)
            CMD_WR_UNIT: begin
                // out-of-range board or slot writes nothing
                if (req.d.board < NUM_BOARDS && req.d.slot < SLOTS_PER_BOARD) begin
                    unit_mapped[ui]  = req.d.entry_valid;
                    unit_quarter[ui] = req.d.quarter;
                    unit_section[ui] = req.d.section;
                end
            end
            CMD_WR_CHAN: begin
                if (req.d.channel < NUM_CHANNELS) begin
                    chan_mapped[req.d.channel] = req.d.entry_valid;
                    chan_row[req.d.channel]    = req.d.local_row;
                    chan_layer[req.d.channel]  = req.d.local_layer;
                end
            end
            CMD_FWD: begin
                // channel checked before unit
                if (req.d.channel >= NUM_CHANNELS || !chan_mapped[req.d.channel]) begin
                    res.st = ST_CHAN_UNMAPPED;
                end else if (req.d.board >= NUM_BOARDS || req.d.slot >= SLOTS_PER_BOARD ||
                             !unit_mapped[ui]) begin
                    res.st = ST_UNIT_UNMAPPED;
                end else begin
                    sec  = unit_section[ui];
                    qtr  = unit_quarter[ui];
                    lr   = chan_row[req.d.channel];
                    ll   = chan_layer[req.d.channel];
                    chip = req.d.chip;
                    if (sec < MIRROR_SECTION) begin
                        row = sec * ROWS_PER_SECTION + lr;
                        lay = qtr * LAYERS_PER_QUARTER + (TOP_CHIP - chip) * LAYERS_PER_CHIP + ll;
                    end else begin
                        // mirrored half: row, layer and chip order flipped
                        row = sec * ROWS_PER_SECTION + (TOP_LOCAL_ROW - lr);
                        lay = qtr * LAYERS_PER_QUARTER + chip * LAYERS_PER_CHIP +
                              (TOP_LOCAL_LAYER - ll);
                    end
                    if (row < 0 || row >= PAD_ROWS || lay < 0 || lay >= PAD_LAYERS) begin
                        res.st = ST_PAD_RANGE;
                    end else begin
                        res.o.out_row   = 7'(row);
                        res.o.out_layer = 7'(lay);
                    end
                end
            end
            CMD_REV: begin
                prow = req.d.pad_row;
                play = req.d.pad_layer;
                if (prow >= PAD_ROWS || play >= PAD_LAYERS) begin
                    res.st = ST_PAD_RANGE;
                end else begin
                    qtr   = play / LAYERS_PER_QUARTER;
                    sec   = prow / ROWS_PER_SECTION;
                    inrow = prow % ROWS_PER_SECTION;
                    inlay = play % LAYERS_PER_QUARTER;
                    if (sec < MIRROR_SECTION) begin
                        chip = TOP_CHIP - inlay / LAYERS_PER_CHIP;
                        lr   = inrow;
                        ll   = inlay % LAYERS_PER_CHIP;
                    end else begin
                        chip = inlay / LAYERS_PER_CHIP;
                        lr   = TOP_LOCAL_ROW - inrow;
                        ll   = TOP_LOCAL_LAYER - inlay % LAYERS_PER_CHIP;
                    end
                    res.o.out_quarter = 2'(qtr);
                    res.o.out_section = 4'(sec);
                    res.o.out_chip    = 2'(chip);
                    res.o.read_row    = 4'(lr);
                    res.o.read_layer  = 3'(ll);
                    // first unit entry, board-major then slot
                    unit_hit = 1'b0;
                    for (i = 0; i < NUM_UNITS && !unit_hit; i++) begin
                        if (unit_mapped[i] && unit_quarter[i] == qtr && unit_section[i] == sec) begin
                            unit_hit        = 1'b1;
                            res.o.out_board = 4'(i / SLOTS_PER_BOARD);
                            res.o.out_slot  = 2'(i % SLOTS_PER_BOARD);
                        end
                    end
                    // lowest mapped channel with these local values
                    chan_hit = 1'b0;
                    for (i = 0; i < NUM_CHANNELS && !chan_hit; i++) begin
                        if (chan_mapped[i] && chan_row[i] == lr && chan_layer[i] == ll) begin
                            chan_hit          = 1'b1;
                            res.o.out_channel = 7'(i);
                        end
                    end
                    if (!unit_hit)
                        res.st = ST_UNIT_MISSING;
                    else if (!chan_hit)
                        res.st = ST_CHAN_MISSING;
                end
            end
            CMD_READ: begin
                if (req.d.channel < NUM_CHANNELS && chan_mapped[req.d.channel]) begin
                    res.o.read_row   = chan_row[req.d.channel];
                    res.o.read_layer = chan_layer[req.d.channel];
                end else begin
                    res.st = ST_CHAN_UNMAPPED;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string msg);
        n_mismatches++;
        if (n_mismatches <= MAX_PRINTS)
            $display("mismatch at result %0d: %s", n_results_seen, msg);
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", what, got, want));
    endtask

    // directed transaction builders
    task automatic unit_write(int b, int s, int q, int sec, bit v);
        mapper_req_t req;
        req               = '0;
        req.op            = CMD_WR_UNIT;
        req.d.board       = 4'(b);
        req.d.slot        = 2'(s);
        req.d.quarter     = 2'(q);
        req.d.section     = 4'(sec);
        req.d.entry_valid = v;
        pending_reqs.push_back(req);
    endtask

    task automatic chan_write(int ch, int r, int l, bit v);
        mapper_req_t req;
        req               = '0;
        req.op            = CMD_WR_CHAN;
        req.d.channel     = 7'(ch);
        req.d.local_row   = 4'(r);
        req.d.local_layer = 3'(l);
        req.d.entry_valid = v;
        pending_reqs.push_back(req);
    endtask

    task automatic fwd_lookup(int b, int s, int chip, int ch);
        mapper_req_t req;
        req           = '0;
        req.op        = CMD_FWD;
        req.d.board   = 4'(b);
        req.d.slot    = 2'(s);
        req.d.chip    = 2'(chip);
        req.d.channel = 7'(ch);
        pending_reqs.push_back(req);
    endtask

    task automatic rev_lookup(int prow, int play);
        mapper_req_t req;
        req             = '0;
        req.op          = CMD_REV;
        req.d.pad_row   = 7'(prow);
        req.d.pad_layer = 7'(play);
        pending_reqs.push_back(req);
    endtask

    task automatic chan_read(int ch);
        mapper_req_t req;
        req           = '0;
        req.op        = CMD_READ;
        req.d.channel = 7'(ch);
        pending_reqs.push_back(req);
    endtask

    task automatic spare_cmd(logic [2:0] op);
        mapper_req_t req;
        req    = '0;
        req.op = op;
        pending_reqs.push_back(req);
    endtask

    // random transaction, restricted to legal table writes while filling
    function automatic mapper_req_t random_request(bit filling);
        mapper_req_t req;
        int          pick;
        req  = '0;
        pick = $urandom_range(0, 99);
        if (filling)
            req.op = (pick < 45) ? CMD_WR_UNIT : CMD_WR_CHAN;
        else if (pick < 14)
            req.op = CMD_WR_UNIT;
        else if (pick < 28)
            req.op = CMD_WR_CHAN;
        else if (pick < 58)
            req.op = CMD_FWD;
        else if (pick < 80)
            req.op = CMD_REV;
        else if (pick < 94)
            req.op = CMD_READ;
        else
            req.op = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        req.d.board       = 4'(pick_field(NUM_BOARDS - 1, filling ? NUM_BOARDS - 1 : 15));
        req.d.slot        = 2'($urandom_range(0, 3));
        req.d.chip        = 2'($urandom_range(0, 3));
        req.d.channel     = pick_field(NUM_CHANNELS - 1, filling ? NUM_CHANNELS - 1 : 127);
        req.d.pad_row     = pick_field(PAD_ROWS - 1, 127);
        req.d.pad_layer   = pick_field(PAD_LAYERS - 1, 127);
        req.d.quarter     = 2'($urandom_range(0, 3));
        req.d.section     = 4'(pick_field(11, filling ? 11 : 15));
        req.d.local_row   = 4'(pick_field(TOP_LOCAL_ROW, filling ? TOP_LOCAL_ROW : 15));
        req.d.local_layer = 3'(pick_field(TOP_LOCAL_LAYER, filling ? TOP_LOCAL_LAYER : 7));
        req.d.entry_valid = filling ? 1'b1 : ($urandom_range(0, 99) < 85);
        return req;
    endfunction

    // sender: one transaction at a time from the pending queue, random gaps between
    always @(posedge i_clk) begin : drive_requests
        pad_result_t res;
        logic        valid_next;
        int          k;
        if (!i_rst_n) begin
            for (k = 0; k < NUM_UNITS; k++) begin
                unit_mapped[k]  = 1'b0;
                unit_quarter[k] = '0;
                unit_section[k] = '0;
            end
            for (k = 0; k < NUM_CHANNELS; k++) begin
                chan_mapped[k] = 1'b0;
                chan_row[k]    = '0;
                chan_layer[k]  = '0;
            end
            s_axis_tvalid <= 1'b0;
        end else begin
            valid_next = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pad_result(cur_req, res);
                pad_results_due.push_back(res);
                n_requests_accepted <= n_requests_accepted + 1;
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() != 0) begin
                    cur_req       = pending_reqs.pop_front();
                    s_axis_tdata <= cur_req.d;
                    s_axis_tuser <= cur_req.op;
                    valid_next    = 1'b1;
                    // keep offering back to back while the receiver holds off
                    send_gap      = (hold_left != 0 || calm) ? 0 : pick_gap();
                end
            end
            s_axis_tvalid <= valid_next;
        end
    end

    // long receiver hold-off at two points of the run so the block backs up
    always @(posedge i_clk) begin : long_hold
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (s_axis_tvalid && s_axis_tready &&
                 (n_requests_accepted == 300 || n_requests_accepted == 900))
            hold_left <= HOLD_CYCLES;
    end

    // receiver: compares each result transaction against the oldest expectation
    always @(posedge i_clk) begin : check_results
        pad_result_t want;
        t_out_data   got;
        logic        ready_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pad_results_due.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, status %0d",
                                              m_axis_tuser));
                end else begin
                    want = pad_results_due.pop_front();
                    check_field("status", m_axis_tuser, want.st);
                    check_field("out_row", got.out_row, want.o.out_row);
                    check_field("out_layer", got.out_layer, want.o.out_layer);
                    check_field("out_quarter", got.out_quarter, want.o.out_quarter);
                    check_field("out_section", got.out_section, want.o.out_section);
                    check_field("out_board", got.out_board, want.o.out_board);
                    check_field("out_slot", got.out_slot, want.o.out_slot);
                    check_field("out_chip", got.out_chip, want.o.out_chip);
                    check_field("out_channel", got.out_channel, want.o.out_channel);
                    check_field("read_row", got.read_row, want.o.read_row);
                    check_field("read_layer", got.read_layer, want.o.read_layer);
                end
                n_results_seen++;
            end
            if (hold_left != 0) begin
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
            m_axis_tready <= ready_next;
        end
    end

    initial begin : run_test
        int i;
        // empty tables: every lookup misses
        fwd_lookup(0, 0, 0, 0);
        chan_read(0);
        rev_lookup(0, 0);
        rev_lookup(PAD_ROWS - 1, PAD_LAYERS - 1);
        // pad off the plane
        rev_lookup(PAD_ROWS, 0);
        rev_lookup(0, PAD_LAYERS);
        rev_lookup(127, 127);
        // table corners, plus writes beyond the tables that must be dropped
        unit_write(0, 0, 0, 0, 1'b1);
        unit_write(NUM_BOARDS - 1, 3, 3, 11, 1'b1);
        unit_write(15, 3, 1, 1, 1'b1);
        chan_write(0, 0, 0, 1'b1);
        chan_write(NUM_CHANNELS - 1, TOP_LOCAL_ROW, TOP_LOCAL_LAYER, 1'b1);
        chan_write(127, 1, 1, 1'b1);
        // forward map, plain and mirrored half, and its two unmapped cases
        fwd_lookup(0, 0, 0, 0);
        fwd_lookup(NUM_BOARDS - 1, 3, 3, NUM_CHANNELS - 1);
        fwd_lookup(0, 0, 1, 100);
        fwd_lookup(15, 3, 2, 0);
        fwd_lookup(1, 0, 0, 0);
        // reverse map hits at both plane corners, then a channel miss
        rev_lookup(0, 0);
        rev_lookup(PAD_ROWS - 1, PAD_LAYERS - 1);
        rev_lookup(1, 0);
        chan_read(NUM_CHANNELS - 1);
        // stored values beyond their ranges push the pad off the plane
        chan_write(5, 15, 7, 1'b1);
        unit_write(2, 1, 3, 15, 1'b1);
        fwd_lookup(2, 1, 0, 5);
        spare_cmd(CMD_SPARE_FIRST);
        spare_cmd(3'd6);
        spare_cmd(CMD_SPARE_LAST);
        // unmapping an entry
        unit_write(0, 0, 0, 0, 1'b0);
        fwd_lookup(0, 0, 0, 0);

        for (i = 0; i < RANDOM_ITEMS; i++)
            pending_reqs.push_back(random_request(i < FILL_ITEMS));
        n_requests_total = pending_reqs.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_requests_accepted < n_requests_total)
            @(posedge i_clk);
        while (pad_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // deadline, well beyond the slowest correct run
    initial begin : watchdog
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
